### sv/assert_macros.svh
// assertion macros used by the command block rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, off while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

`endif

### sv/owts_pkg.sv
// types, codes and the crc helper for the one-wire temperature sensor command block
package owts_pkg;

    typedef enum logic [1:0] {
        MODE_RESET = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    typedef enum logic [7:0] {
        CMD_READ_ROM   = 8'hF0,
        CMD_RECALL_PWR = 8'hB4,
        CMD_CONVERT    = 8'h44,
        CMD_READ_SCR   = 8'hBE
    } t_cmd;

    typedef enum logic [1:0] {
        SRC_NONE    = 2'd0,
        SRC_SERIAL  = 2'd1,
        SRC_SCRATCH = 2'd2
    } t_src;

    localparam logic CFG_TEMPERATURE = 1'b0;
    localparam logic CFG_SERIAL      = 1'b1;

    localparam logic [3:0] SERIAL_BYTES  = 4'd8;
    localparam logic [3:0] SCRATCH_BYTES = 4'd9;

    localparam logic [7:0] CRC_POLY  = 8'h8C;
    localparam logic [7:0] FILL_BYTE = 8'hFF;

    // x / 100 == (x * 83887) >> 23 for every 16-bit x
    localparam logic [16:0] DIV100_MUL   = 17'd83887;
    localparam int          DIV100_SHIFT = 23;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       read_valid;
        logic       presence_echo;
        logic [3:0] bytes_left;
    } t_out;

    // reflected crc8, lsb first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] d;
        c = crc_in;
        d = b;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ d[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

    // crc over scratchpad bytes 0..7 where bytes 2..7 always hold zero
    function automatic logic [7:0] crc8_convert(input logic [15:0] conv);
        logic [7:0] c;
        c = crc8_byte(8'h00, conv[7:0]);
        c = crc8_byte(c, conv[15:8]);
        for (int k = 0; k < 6; k++) begin
            c = crc8_byte(c, 8'h00);
        end
        return c;
    endfunction

endpackage

### sv/one_wire_temp_sensor_cmd.sv
// Byte-level one-wire temperature sensor slave: bus resets, command bytes and
// byte reads in, one result per item out. One item is taken every clock cycle
// while o_in_stall is low; each item passes an input register and a result
// register before its result is offered. The rate is set by the single decode
// pass that updates the queue and scratchpad state between those two registers.
// The temperature is scaled (divide by 100, shift left by 4) when the temperature
// register is written, so a convert command only copies it and computes its crc.
`include "assert_macros.svh"

module one_wire_temp_sensor_cmd (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  owts_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output owts_pkg::t_out    o_out_data
);

    logic           r_in_valid;
    owts_pkg::t_in  r_in;
    logic           r_out_valid;
    owts_pkg::t_out r_out;

    logic [63:0]    r_serial;
    logic [15:0]    r_conv;
    logic [7:0]     r_scr0;
    logic [7:0]     r_scr1;
    logic [7:0]     r_scr8;
    owts_pkg::t_src r_src;
    logic [3:0]     r_idx;
    logic [3:0]     r_rem;

    owts_pkg::t_src n_src;
    logic [3:0]     n_idx;
    logic [3:0]     n_rem;
    logic [7:0]     n_scr0;
    logic [7:0]     n_scr1;
    logic [7:0]     n_scr8;
    owts_pkg::t_out n_out;

    logic           advance;
    logic           process;
    logic           in_xfer;
    logic [32:0]    div_prod;
    logic [15:0]    conv_value;
    logic [7:0]     rd_byte;
    logic           rd_ok;

    assign advance     = !r_out_valid || !i_out_stall;
    assign process     = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // scaled temperature, computed once at register write; the quotient fits in 10 bits
    assign div_prod   = 33'(i_cfg_data[15:0]) * 33'(owts_pkg::DIV100_MUL);
    assign conv_value = {2'b00, div_prod[owts_pkg::DIV100_SHIFT +: 10], 4'b0000};

    // byte fetch for a read; scratchpad bytes 2..7 are never written and stay zero
    always_comb begin
        rd_byte = 8'h00;
        rd_ok   = 1'b0;
        if (r_rem != 4'd0) begin
            if (r_src == owts_pkg::SRC_SERIAL && r_idx < owts_pkg::SERIAL_BYTES) begin
                rd_byte = r_serial[{r_idx[2:0], 3'b000} +: 8];
                rd_ok   = 1'b1;
            end else if (r_src == owts_pkg::SRC_SCRATCH && r_idx < owts_pkg::SCRATCH_BYTES) begin
                rd_ok = 1'b1;
                case (r_idx)
                    4'd0:    rd_byte = r_scr0;
                    4'd1:    rd_byte = r_scr1;
                    4'd8:    rd_byte = r_scr8;
                    default: rd_byte = 8'h00;
                endcase
            end
        end
    end

    always_comb begin
        n_src  = r_src;
        n_idx  = r_idx;
        n_rem  = r_rem;
        n_scr0 = r_scr0;
        n_scr1 = r_scr1;
        n_scr8 = r_scr8;
        n_out  = '0;
        case (owts_pkg::t_mode'(r_in.mode))
            owts_pkg::MODE_RESET: begin
                n_out.presence_echo = 1'b1;
            end
            owts_pkg::MODE_WRITE: begin
                case (owts_pkg::t_cmd'(r_in.data_byte))
                    owts_pkg::CMD_READ_ROM: begin
                        n_src = owts_pkg::SRC_SERIAL;
                        n_idx = 4'd0;
                        n_rem = owts_pkg::SERIAL_BYTES;
                    end
                    owts_pkg::CMD_RECALL_PWR: begin
                        n_scr0 = owts_pkg::FILL_BYTE;
                        n_src  = owts_pkg::SRC_SCRATCH;
                        n_idx  = 4'd0;
                        n_rem  = 4'd1;
                    end
                    owts_pkg::CMD_CONVERT: begin
                        n_scr0 = r_conv[7:0];
                        n_scr1 = r_conv[15:8];
                        n_scr8 = owts_pkg::crc8_convert(r_conv);
                    end
                    owts_pkg::CMD_READ_SCR: begin
                        n_src = owts_pkg::SRC_SCRATCH;
                        n_idx = 4'd0;
                        n_rem = owts_pkg::SCRATCH_BYTES;
                    end
                    default: begin
                    end
                endcase
            end
            owts_pkg::MODE_READ: begin
                if (rd_ok) begin
                    n_out.read_byte  = rd_byte;
                    n_out.read_valid = 1'b1;
                    n_idx            = r_idx + 4'd1;
                    n_rem            = r_rem - 4'd1;
                end
            end
            default: begin
            end
        endcase
        n_out.bytes_left = n_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_serial    <= '0;
            r_conv      <= '0;
            r_scr0      <= '0;
            r_scr1      <= '0;
            r_scr8      <= '0;
            r_src       <= owts_pkg::SRC_NONE;
            r_idx       <= '0;
            r_rem       <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (process) begin
                r_src  <= n_src;
                r_idx  <= n_idx;
                r_rem  <= n_rem;
                r_scr0 <= n_scr0;
                r_scr1 <= n_scr1;
                r_scr8 <= n_scr8;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    owts_pkg::CFG_TEMPERATURE: r_conv   <= conv_value;
                    owts_pkg::CFG_SERIAL:      r_serial <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
        if (process) begin
            r_out <= n_out;
        end
    end

    // queue never runs past the end of the scratchpad, the longest source
    `ASSERT_CLK(a_queue_bound, i_clk, i_rst_n, ({1'b0, r_idx} + {1'b0, r_rem} <= 5'd9))
    // pending bytes always have a source
    `ASSERT_CLK(a_queue_src, i_clk, i_rst_n, (r_rem == 4'd0 || r_src != owts_pkg::SRC_NONE))
    // a read result and a presence echo never come together
    `ASSERT_CLK(a_out_excl, i_clk, i_rst_n, (o_out_valid |-> !(o_out_data.read_valid && o_out_data.presence_echo)))
    // a delivered byte takes one from the queue
    `ASSERT_CLK(a_read_count, i_clk, i_rst_n, ((process && n_out.read_valid) |=> (r_rem == $past(r_rem) - 4'd1)))

endmodule

### sim/tb_one_wire_temp_sensor_cmd.sv
// self-checking testbench for the one-wire temperature sensor command block
module tb_one_wire_temp_sensor_cmd;

    localparam logic [1:0] MODE_UNUSED      = 2'd3;
    localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
    localparam int         CENTI_PER_DEGREE = 100;
    localparam int         FRAC_BITS        = 4;
    localparam int         SETTLE_CYCLES    = 6;
    localparam int         LONG_HOLD        = 300;
    localparam int         PHASE_ITEMS      = 200;
    localparam int         NUM_PHASES       = 8;

    class sensor_scoreboard;
        logic [15:0]     temp_centi;
        logic [63:0]     serial;
        logic [7:0]      scratch [0:8];
        owts_pkg::t_src  src;
        logic [3:0]      idx;
        logic [3:0]      left;
        owts_pkg::t_out  expected_q[$];
        int              errors;
        int              n_items;
        int              n_results;
        int              n_delivered;
        int              n_converts;

        function new();
            temp_centi = '0;
            serial     = '0;
            foreach (scratch[i]) scratch[i] = '0;
            src         = owts_pkg::SRC_NONE;
            idx         = '0;
            left        = '0;
            errors      = 0;
            n_items     = 0;
            n_results   = 0;
            n_delivered = 0;
            n_converts  = 0;
        endfunction

        function void write_register(logic reg_idx, logic [63:0] value);
            if (reg_idx == owts_pkg::CFG_TEMPERATURE) begin
                temp_centi = value[15:0];
            end else begin
                serial = value;
            end
        endfunction

        // crc8, reflected poly, lsb first, over scratchpad bytes 0..7
        function logic [7:0] scratch_crc();
            logic [7:0] crc;
            logic [7:0] b;
            logic       mix;
            crc = '0;
            for (int n = 0; n < 8; n++) begin
                b = scratch[n];
                for (int k = 0; k < 8; k++) begin
                    mix = crc[0] ^ b[0];
                    crc = crc >> 1;
                    if (mix) crc = crc ^ owts_pkg::CRC_POLY;
                    b = b >> 1;
                end
            end
            return crc;
        endfunction

        function void start_queue(owts_pkg::t_src s, logic [3:0] count);
            src  = s;
            idx  = '0;
            left = count;
        endfunction

        function void run_command(logic [7:0] cmd);
            logic [15:0] deg;
            logic [15:0] conv;
            case (cmd)
                owts_pkg::CMD_READ_ROM: begin
                    start_queue(owts_pkg::SRC_SERIAL, owts_pkg::SERIAL_BYTES);
                end
                owts_pkg::CMD_RECALL_PWR: begin
                    scratch[0] = owts_pkg::FILL_BYTE;
                    start_queue(owts_pkg::SRC_SCRATCH, 4'd1);
                end
                owts_pkg::CMD_CONVERT: begin
                    deg        = 16'(temp_centi / CENTI_PER_DEGREE);
                    conv       = deg << FRAC_BITS;
                    scratch[0] = conv[7:0];
                    scratch[1] = conv[15:8];
                    scratch[8] = scratch_crc();
                    n_converts++;
                end
                owts_pkg::CMD_READ_SCR: begin
                    start_queue(owts_pkg::SRC_SCRATCH, owts_pkg::SCRATCH_BYTES);
                end
                default: ;
            endcase
        endfunction

        // bytes are taken from the live store at read time
        function bit fetch_byte(output logic [7:0] b);
            b = '0;
            if (left == 0) return 1'b0;
            if (src == owts_pkg::SRC_SERIAL && idx < owts_pkg::SERIAL_BYTES) begin
                b = serial[8*idx +: 8];
            end else if (src == owts_pkg::SRC_SCRATCH && idx < owts_pkg::SCRATCH_BYTES) begin
                b = scratch[idx];
            end else begin
                return 1'b0;
            end
            idx  = idx + 4'd1;
            left = left - 4'd1;
            return 1'b1;
        endfunction

        function void note_item(owts_pkg::t_in item);
            owts_pkg::t_out res;
            logic [7:0]     b;
            res = '0;
            case (item.mode)
                owts_pkg::MODE_RESET: res.presence_echo = 1'b1;
                owts_pkg::MODE_WRITE: run_command(item.data_byte);
                owts_pkg::MODE_READ: begin
                    if (fetch_byte(b)) begin
                        res.read_byte  = b;
                        res.read_valid = 1'b1;
                        n_delivered++;
                    end
                end
                default: ;
            endcase
            res.bytes_left = left;
            expected_q.push_back(res);
            n_items++;
        endfunction

        function void check_result(owts_pkg::t_out got);
            owts_pkg::t_out exp_res;
            n_results++;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: %h", got);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.read_byte !== exp_res.read_byte) begin
                $error("read_byte: expected %0h, got %0h", exp_res.read_byte, got.read_byte);
                errors++;
            end
            if (got.read_valid !== exp_res.read_valid) begin
                $error("read_valid: expected %0b, got %0b", exp_res.read_valid, got.read_valid);
                errors++;
            end
            if (got.presence_echo !== exp_res.presence_echo) begin
                $error("presence_echo: expected %0b, got %0b",
                       exp_res.presence_echo, got.presence_echo);
                errors++;
            end
            if (got.bytes_left !== exp_res.bytes_left) begin
                $error("bytes_left: expected %0d, got %0d", exp_res.bytes_left, got.bytes_left);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic            i_cfg_index;
    logic [63:0]     i_cfg_data;
    logic            i_in_valid;
    logic            o_in_stall;
    owts_pkg::t_in   i_in_data;
    logic            o_out_valid;
    logic            i_out_stall;
    owts_pkg::t_out  o_out_data;

    sensor_scoreboard sb = new();

    bit no_idle;
    bit long_hold_req;
    int n_sent;

    one_wire_temp_sensor_cmd dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_item(i_in_data);
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_data);
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic [1:0] mode, input logic [7:0] data);
        owts_pkg::t_in item;
        item.mode      = mode;
        item.data_byte = data;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
        // gap after the transfer, except in the quiet tail of the run
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic send_reads(input int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 11) == 0) send_item(owts_pkg::MODE_RESET, 8'($urandom));
            send_item(owts_pkg::MODE_READ, 8'($urandom));
        end
    endtask

    // let the clock tick first so the last transfer is already noted by the monitor
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [15:0] temp, input logic [63:0] ser);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= owts_pkg::CFG_TEMPERATURE;
        i_cfg_data  <= {48'd0, temp};
        @(posedge i_clk);
        sb.write_register(owts_pkg::CFG_TEMPERATURE, {48'd0, temp});
        i_cfg_index <= owts_pkg::CFG_SERIAL;
        i_cfg_data  <= ser;
        @(posedge i_clk);
        sb.write_register(owts_pkg::CFG_SERIAL, ser);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_traffic(input int count);
        int target;
        int noise;
        target = n_sent + count;
        while (n_sent < target) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    send_item(owts_pkg::MODE_WRITE, owts_pkg::CMD_READ_ROM);
                    send_reads($urandom_range(6, 10));
                end
                2, 3: begin
                    send_item(owts_pkg::MODE_WRITE, owts_pkg::CMD_READ_SCR);
                    send_reads($urandom_range(7, 11));
                end
                4: begin
                    send_item(owts_pkg::MODE_WRITE, owts_pkg::CMD_CONVERT);
                    send_item(owts_pkg::MODE_WRITE, owts_pkg::CMD_READ_SCR);
                    send_reads($urandom_range(0, 10));
                end
                5: begin
                    send_item(owts_pkg::MODE_WRITE, owts_pkg::CMD_RECALL_PWR);
                    send_reads($urandom_range(0, 2));
                end
                6: send_item(owts_pkg::MODE_RESET, 8'($urandom));
                7: send_item(owts_pkg::MODE_WRITE, owts_pkg::CMD_CONVERT);
                default: begin
                    noise = $urandom_range(1, 4);
                    repeat (noise) send_item(2'($urandom_range(0, 3)), 8'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        logic [15:0] temp;
        logic [63:0] ser;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= 1'b0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        no_idle       = 1'b0;
        long_hold_req = 1'b0;
        n_sent        = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty read, bus reset, ignored bytes, unused mode, each command
        send_item(owts_pkg::MODE_READ, 8'h00);
        send_item(owts_pkg::MODE_RESET, 8'hFF);
        send_item(owts_pkg::MODE_WRITE, 8'h00);
        send_item(owts_pkg::MODE_WRITE, CMD_SKIP_ROM);
        send_item(MODE_UNUSED, 8'hFF);
        wait_drained();
        write_config(16'hFFFF, 64'h0123_4567_89AB_CDEF);
        send_item(owts_pkg::MODE_WRITE, owts_pkg::CMD_CONVERT);
        send_item(owts_pkg::MODE_WRITE, owts_pkg::CMD_READ_SCR);
        send_reads(9);
        send_item(owts_pkg::MODE_WRITE, owts_pkg::CMD_READ_ROM);
        send_item(owts_pkg::MODE_READ, 8'hFF);
        send_item(owts_pkg::MODE_READ, 8'h00);
        send_item(owts_pkg::MODE_READ, 8'h5A);
        // bus reset keeps the queue
        send_item(owts_pkg::MODE_RESET, 8'h00);
        send_item(owts_pkg::MODE_READ, 8'hA5);
        send_item(owts_pkg::MODE_WRITE, owts_pkg::CMD_RECALL_PWR);
        send_item(owts_pkg::MODE_READ, 8'h00);
        // queue already drained
        send_item(owts_pkg::MODE_READ, 8'h00);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: begin temp = 16'hFFFF; ser = '1; end
                1: begin temp = 16'd0; ser = '0; end
                3: begin temp = 16'd99; ser = 64'h8000_0000_0000_0001; end
                4: begin temp = 16'd100; ser = {$urandom, $urandom}; end
                default: begin temp = 16'($urandom); ser = {$urandom, $urandom}; end
            endcase
            write_config(temp, ser);
            if (phase == 1) long_hold_req = 1'b1;
            if (phase == NUM_PHASES - 1) no_idle = 1'b1;
            random_traffic(PHASE_ITEMS);
        end

        wait_drained();
        $display("covered %0d items over %0d register settings; %0d results checked",
                 sb.n_items, NUM_PHASES + 1, sb.n_results);
        $display("%0d bytes read out, %0d conversions, one long output hold-off",
                 sb.n_delivered, sb.n_converts);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/owts_pkg.sv
sv/one_wire_temp_sensor_cmd.sv
sim/tb_one_wire_temp_sensor_cmd.sv
